/* sv/dtsp_pkg.sv */
// Shared types, constants and register indexes for the dual throttle slew PWM core.
// Depends on nothing; every other file imports it.
package dtsp_pkg;

  localparam int PWM_BITS_DEF = 12;
  localparam int CMD_FRAC_BITS_DEF = 14;

  // Width of the duty divider; it retires two quotient bits a cycle, so it must be even.
  localparam int DIV_W = 32;
  localparam int DIV_STEPS = DIV_W / 2;

  // Slew scaling by 1/1000: drop three bits, then multiply by a reciprocal of 125 that is
  // exact for every product below the saturation point.
  localparam int SLEW_PROD_W = 52;
  localparam logic [SLEW_PROD_W-1:0] SLEW_SAT = 52'd65536000;
  localparam logic [23:0] RECIP_125 = 24'd8589935;
  localparam int RECIP_SHIFT = 30;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd5;

  typedef struct packed {
    logic [15:0] min_active_level_mv;
    logic [15:0] max_level_mv;
    logic [15:0] deadband_floor_mv;
    logic [19:0] rise_rate_mv_per_s;
    logic [19:0] fall_rate_mv_per_s;
    logic [15:0] full_scale_mv;
  } cfg_t;

  typedef struct packed {
    logic               enable;
    logic               brake_request;
    logic signed [15:0] left_command;
    logic signed [15:0] right_command;
    logic               left_rev_req;
    logic               right_rev_req;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] left_duty;
    logic [15:0] right_duty;
    logic [15:0] left_level_mv;
    logic [15:0] right_level_mv;
    logic        left_reverse_out;
    logic        right_reverse_out;
    logic        drive_enable_out;
    logic        brake_out;
  } out_t;

  typedef struct packed {
    logic        done;
    logic [15:0] level;
    logic [15:0] duty;
  } lane_out_t;

endpackage

/* sv/dtsp_div.sv */
// Iterative unsigned divider, two quotient bits per cycle, used by each lane.
// Depends on dtsp_pkg for the dividend width.
module dtsp_div
  import dtsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [16:0]      rem;
  logic [15:0]      dsr;

  logic [16:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem[15:0], dvd[DIV_W-1]};
    ge1 = r1 >= {1'b0, dsr};
    r1s = ge1 ? r1 - {1'b0, dsr} : r1;
    r2  = {r1s[15:0], dvd[DIV_W-2]};
    ge2 = r2 >= {1'b0, dsr};
    r2s = ge2 ? r2 - {1'b0, dsr} : r2;
  end

  // Quotient bits shift into the dividend register as its bits are consumed.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-3:0], ge1, ge2};
      rem <= r2s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

/* sv/dtsp_lane.sv */
// One throttle channel: command mapping, slew limit and duty computation.
// Depends on dtsp_pkg and dtsp_div; holds the channel's last level.
module dtsp_lane
  import dtsp_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF,
  parameter int CMD_FRAC_BITS = CMD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               clear,
  input  logic signed [15:0] cmd,
  input  logic [31:0]        dt,
  input  cfg_t               cfg,
  output lane_out_t          res
);

  localparam int MAG_W = CMD_FRAC_BITS + 1;
  localparam int PW = MAG_W + 18;
  localparam logic [16:0] CMD_ONE = 17'(1 << CMD_FRAC_BITS);
  localparam logic [PW-1:0] CMD_HALF = PW'(1 << (CMD_FRAC_BITS - 1));
  localparam logic [15:0] MAX_DUTY = 16'((1 << PWM_BITS) - 1);

  typedef enum logic [8:0] {
    L_IDLE  = 9'b000000001,
    L_MUL   = 9'b000000010,
    L_MAP   = 9'b000000100,
    L_ML    = 9'b000001000,
    L_MH    = 9'b000010000,
    L_SCALE = 9'b000100000,
    L_SLEW  = 9'b001000000,
    L_DMUL  = 9'b010000000,
    L_DIV2  = 9'b100000000
  } lane_state_t;

  lane_state_t        state;
  logic [MAG_W-1:0]   mag;
  logic signed [PW-1:0] prod;
  logic [15:0]        target;
  logic [15:0]        level;
  logic [15:0]        duty;
  logic [19:0]        rate;
  logic [35:0]        prod_lo;
  logic [31:0]        dt_r;
  logic [31:0]        dprod;
  logic [SLEW_PROD_W-1:0] sprod;
  logic [15:0]        md;
  logic               md_sat;
  logic               done;

  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [15:0]      div_dsr;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  logic [16:0] abs_cmd;
  logic [16:0] mag_cl;
  logic signed [17:0] span;
  logic [PW-1:0] absp;
  logic [PW-1:0] rq_full;
  logic [16:0] rq;
  logic signed [18:0] rounded, mapped;
  logic [15:0] target_next;
  logic [35:0] prod_hi;
  logic [SLEW_PROD_W-1:0] slew_prod;
  logic [22:0] ms_y;
  logic [46:0] ms_prod;
  logic signed [16:0] delta;
  logic [15:0] level_next;

  always_comb begin
    abs_cmd = cmd[15] ? 17'(-{cmd[15], cmd}) : {1'b0, cmd};
    mag_cl  = (abs_cmd > CMD_ONE) ? CMD_ONE : abs_cmd;
    span    = $signed({2'b0, cfg.max_level_mv}) - $signed({2'b0, cfg.min_active_level_mv});

    // Round half away from zero on the magnitude, then restore the sign.
    absp    = prod[PW-1] ? PW'(-prod) : PW'(prod);
    rq_full = (absp + CMD_HALF) >> CMD_FRAC_BITS;
    rq      = rq_full[16:0];
    rounded = prod[PW-1] ? -$signed({2'b0, rq}) : $signed({2'b0, rq});
    mapped  = $signed({3'b0, cfg.min_active_level_mv}) + rounded;
    if (mapped > $signed({3'b0, cfg.max_level_mv})) mapped = $signed({3'b0, cfg.max_level_mv});
    if (mapped < $signed({3'b0, cfg.deadband_floor_mv}))
      mapped = $signed({3'b0, cfg.deadband_floor_mv});
    target_next = (mag == '0) ? 16'd0 : mapped[15:0];

    prod_hi   = rate * dt_r[31:16];
    slew_prod = SLEW_PROD_W'(prod_lo) + (SLEW_PROD_W'(prod_hi) << 16);

    // Below the saturation point the product fits in 26 bits.
    ms_y    = sprod[25:3];
    ms_prod = ms_y * RECIP_125;

    // A saturated step is larger than any possible gap, so the target is reached.
    delta = $signed({1'b0, target}) - $signed({1'b0, level});
    if (md_sat) begin
      level_next = target;
    end else if (md == '0) begin
      level_next = level;
    end else if (delta > $signed({1'b0, md})) begin
      level_next = level + md;
    end else if (delta < -$signed({1'b0, md})) begin
      level_next = level - md;
    end else begin
      level_next = target;
    end

    div_start = (state == L_DMUL) && (cfg.full_scale_mv != '0);
    div_dvd   = DIV_W'(dprod);
    div_dsr   = cfg.full_scale_mv;
  end

  dtsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: if (start) begin
        mag  <= mag_cl[MAG_W-1:0];
        dt_r <= dt;
      end
      L_MUL: prod <= $signed({1'b0, mag}) * span;
      L_MAP: target <= target_next;
      L_ML: begin
        rate    <= (target > level) ? cfg.rise_rate_mv_per_s : cfg.fall_rate_mv_per_s;
        prod_lo <= ((target > level) ? cfg.rise_rate_mv_per_s : cfg.fall_rate_mv_per_s)
                   * dt_r[15:0];
      end
      L_MH: sprod <= slew_prod;
      L_SCALE: begin
        md     <= ms_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        md_sat <= (sprod >= SLEW_SAT);
      end
      L_SLEW: dprod <= 32'(((level_next > cfg.full_scale_mv) ? cfg.full_scale_mv : level_next)
                        * MAX_DUTY);
      L_DIV2: if (div_done) duty <= div_q[15:0];
      default: ;
    endcase
    if (state == L_DMUL && cfg.full_scale_mv == '0) duty <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      level <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clear) level <= '0;
      case (state)
        L_IDLE: if (start) state <= L_MUL;
        L_MUL:   state <= L_MAP;
        L_MAP:   state <= L_ML;
        L_ML:    state <= L_MH;
        L_MH:    state <= L_SCALE;
        L_SCALE: state <= L_SLEW;
        L_SLEW: begin
          level <= level_next;
          state <= L_DMUL;
        end
        L_DMUL: begin
          if (cfg.full_scale_mv == '0) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            state <= L_DIV2;
          end
        end
        L_DIV2: if (div_done) begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign res.done  = done;
  assign res.level = level;
  assign res.duty  = duty;

endmodule

/* sv/dual_throttle_slew_pwm_core.sv */
// Dual throttle slew PWM core: two command lanes side by side, merged into one result.
// Depends on dtsp_pkg, dtsp_lane and dtsp_div.
//
// Each accepted command yields exactly one result. A stop command (enable low or brake
// high) moves the control straight to the finish state, and its result is loaded into the
// output register from there. A running command starts both lanes, which work in lockstep:
// each lane maps the command and applies the reciprocal slew scaling, then runs its
// iterative duty divide (two quotient bits a cycle); when both lanes are done the control
// moves to the finish state and the merge loads the output register. With full scale at
// zero the divide is skipped. A new command is accepted only once the previous result has
// been loaded into the output register, so a stalled output also holds off new commands.
// Configuration writes are always ready and take effect at once.
module dual_throttle_slew_pwm_core
  import dtsp_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF,
  parameter int CMD_FRAC_BITS = CMD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [19:0]          cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_FIN  = 3'b100
  } top_state_t;

  top_state_t state;
  cfg_t       cfg;
  logic [31:0] last_time_ms;
  logic        stop_r, lrev_r, rrev_r;
  logic [1:0]  lane_done;
  lane_out_t   lres, rres;

  logic        accept, is_stop, run_start, load_out;
  logic [31:0] base_time, dt;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_stop   = !in_data.enable || in_data.brake_request;
  assign run_start = accept && !is_stop;
  assign base_time = (last_time_ms == '0) ? in_data.now_ms : last_time_ms;
  assign dt        = in_data.now_ms - base_time;
  assign load_out  = (state == T_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_active_level_mv <= 16'd1000;
      cfg.max_level_mv        <= 16'd4200;
      cfg.deadband_floor_mv   <= 16'd800;
      cfg.rise_rate_mv_per_s  <= 20'd2000;
      cfg.fall_rate_mv_per_s  <= 20'd4000;
      cfg.full_scale_mv       <= 16'd5000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_ACTIVE: cfg.min_active_level_mv <= cfg_data[15:0];
        CFG_MAX_LEVEL:  cfg.max_level_mv        <= cfg_data[15:0];
        CFG_DEADBAND:   cfg.deadband_floor_mv   <= cfg_data[15:0];
        CFG_RISE_RATE:  cfg.rise_rate_mv_per_s  <= cfg_data;
        CFG_FALL_RATE:  cfg.fall_rate_mv_per_s  <= cfg_data;
        CFG_FULL_SCALE: cfg.full_scale_mv       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dtsp_lane #(.PWM_BITS(PWM_BITS), .CMD_FRAC_BITS(CMD_FRAC_BITS)) u_left (
    .clk   (clk),
    .rst   (rst),
    .start (run_start),
    .clear (accept && is_stop),
    .cmd   (in_data.left_command),
    .dt    (dt),
    .cfg   (cfg),
    .res   (lres)
  );

  dtsp_lane #(.PWM_BITS(PWM_BITS), .CMD_FRAC_BITS(CMD_FRAC_BITS)) u_right (
    .clk   (clk),
    .rst   (rst),
    .start (run_start),
    .clear (accept && is_stop),
    .cmd   (in_data.right_command),
    .dt    (dt),
    .cfg   (cfg),
    .res   (rres)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      stop_r <= is_stop;
      lrev_r <= in_data.left_rev_req;
      rrev_r <= in_data.right_rev_req;
    end
    // Merge stage: the lanes' levels and duties combine with the control lines here.
    if (load_out) begin
      if (stop_r) begin
        out_data.left_duty         <= '0;
        out_data.right_duty        <= '0;
        out_data.left_level_mv     <= '0;
        out_data.right_level_mv    <= '0;
        out_data.left_reverse_out  <= 1'b0;
        out_data.right_reverse_out <= 1'b0;
        out_data.drive_enable_out  <= 1'b0;
        out_data.brake_out         <= 1'b1;
      end else begin
        out_data.left_duty         <= lres.duty;
        out_data.right_duty        <= rres.duty;
        out_data.left_level_mv     <= lres.level;
        out_data.right_level_mv    <= rres.level;
        out_data.left_reverse_out  <= lrev_r;
        out_data.right_reverse_out <= rrev_r;
        out_data.drive_enable_out  <= 1'b1;
        out_data.brake_out         <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      last_time_ms <= '0;
      lane_done    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) last_time_ms <= in_data.now_ms;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        T_IDLE: if (accept) begin
          lane_done <= '0;
          state     <= is_stop ? T_FIN : T_RUN;
        end
        T_RUN: begin
          if ((lane_done[0] || lres.done) && (lane_done[1] || rres.done)) begin
            state <= T_FIN;
          end
          lane_done <= lane_done | {rres.done, lres.done};
        end
        T_FIN: if (load_out) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_dual_throttle_slew_pwm_core.sv */
// Self-checking testbench for dual_throttle_slew_pwm_core: directed commands, then random
// command streams under several register settings, with random stalls on both channels.
// Depends on dtsp_pkg and the core RTL.
module tb_dual_throttle_slew_pwm_core;
  import dtsp_pkg::*;

  localparam longint CMD_ONE = longint'(1) << CMD_FRAC_BITS_DEF;
  localparam longint DUTY_MAX = (longint'(1) << PWM_BITS_DEF) - 1;
  localparam int RANDOM_PER_PHASE = 265;
  localparam int NUM_PHASES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_ACTIVE;
  logic [19:0] cfg_data = '0;

  // Predictor copy of the registers and state.
  longint unsigned m_min, m_max, m_floor, m_rise, m_fall, m_fs;
  longint unsigned m_last_time, m_left, m_right;

  out_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int stops_seen = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  longint unsigned cur_time = 0;

  typedef struct {
    in_t  cmd;
    bit   typed;
  } stim_row_t;

  dual_throttle_slew_pwm_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint map_target(logic signed [15:0] c);
    longint v, mag, span, prod, rnd, m;
    v = c;
    mag = (v < 0) ? -v : v;
    if (mag > CMD_ONE) mag = CMD_ONE;
    if (mag == 0) return 0;
    span = longint'(m_max) - longint'(m_min);
    prod = mag * span;
    if (prod >= 0) rnd = (prod + CMD_ONE / 2) / CMD_ONE;
    else rnd = -((-prod + CMD_ONE / 2) / CMD_ONE);
    m = longint'(m_min) + rnd;
    if (m > longint'(m_max)) m = m_max;
    if (m < longint'(m_floor)) m = m_floor;
    return m;
  endfunction

  function automatic longint unsigned slew_limit(longint target, longint unsigned prev,
                                                 longint unsigned dt);
    longint delta, maxd;
    longint unsigned rate;
    delta = target - longint'(prev);
    rate = (delta > 0) ? m_rise : m_fall;
    maxd = longint'((rate * dt) / 1000);
    if (maxd <= 0) return prev;
    if (delta > maxd) return (prev + maxd) & 16'hFFFF;
    if (delta < -maxd) return (prev - maxd) & 16'hFFFF;
    return target & 16'hFFFF;
  endfunction

  function automatic logic [15:0] duty_of(longint unsigned level);
    longint unsigned safe;
    if (m_fs == 0) return '0;
    safe = (level > m_fs) ? m_fs : level;
    return 16'((safe * DUTY_MAX) / m_fs);
  endfunction

  // Works out the result of one command and advances the predictor state.
  function automatic out_t predict_result(in_t c);
    out_t r;
    longint unsigned dt;
    r = '0;
    if (!c.enable || c.brake_request) begin
      m_left = 0;
      m_right = 0;
      m_last_time = c.now_ms;
      r.brake_out = 1'b1;
      return r;
    end
    if (m_last_time == 0) m_last_time = c.now_ms;
    dt = (longint'(c.now_ms) - longint'(m_last_time)) & 32'hFFFFFFFF;
    m_left = slew_limit(map_target(c.left_command), m_left, dt);
    m_right = slew_limit(map_target(c.right_command), m_right, dt);
    m_last_time = c.now_ms;
    r.left_duty = duty_of(m_left);
    r.right_duty = duty_of(m_right);
    r.left_level_mv = m_left[15:0];
    r.right_level_mv = m_right[15:0];
    r.left_reverse_out = c.left_rev_req;
    r.right_reverse_out = c.right_rev_req;
    r.drive_enable_out = 1'b1;
    return r;
  endfunction

  function automatic in_t make_cmd(bit en, bit brk, logic [15:0] l, logic [15:0] r,
                                   bit lr, bit rr, logic [31:0] now);
    in_t c;
    c.enable = en;
    c.brake_request = brk;
    c.left_command = l;
    c.right_command = r;
    c.left_rev_req = lr;
    c.right_rev_req = rr;
    c.now_ms = now;
    return c;
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", checked, field, got, want);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no gap; the caller drops it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_MIN_ACTIVE: m_min = value[15:0];
      CFG_MAX_LEVEL:  m_max = value[15:0];
      CFG_DEADBAND:   m_floor = value[15:0];
      CFG_RISE_RATE:  m_rise = value;
      CFG_FALL_RATE:  m_fall = value;
      CFG_FULL_SCALE: m_fs = value[15:0];
      default: ;
    endcase
  endtask

  // Writes all six registers; the 16-bit ones get junk above bit 15 that must be dropped.
  task automatic load_setting(logic [15:0] mn, logic [15:0] mx, logic [15:0] fl,
                              logic [19:0] rise, logic [19:0] fall, logic [15:0] fs);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_MIN_ACTIVE, {4'($urandom), mn});
    write_reg(CFG_MAX_LEVEL, {4'($urandom), mx});
    write_reg(CFG_DEADBAND, {4'($urandom), fl});
    write_reg(CFG_RISE_RATE, rise);
    write_reg(CFG_FALL_RATE, fall);
    write_reg(CFG_FULL_SCALE, {4'($urandom), fs});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cmd(in_t c, bit typed);
    out_t want;
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    want = predict_result(c);
    if (typed) begin
      want = '0;
      want.brake_out = 1'b1;
    end
    pending_results.push_back(want);
    items_sent++;
    if (items_sent == 300) hold_go = 1'b1;
    quiet = (items_sent >= 600 && items_sent < 900);
    if (!quiet && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_command();
    logic [15:0] picks[7] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h0001,
                              16'hFFFF};
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return picks[$urandom_range(0, 6)];
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic random_cmds(int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) cur_time = cur_time + $urandom_range(0, 1500);
      else if (pick < 80) cur_time = cur_time + $urandom_range(0, 20);
      else if (pick < 88) cur_time = $urandom;
      else if (pick < 92) cur_time = 0;
      else cur_time = cur_time + $urandom_range(10000, 3000000);
      cur_time = cur_time & 32'hFFFFFFFF;
      send_cmd(make_cmd($urandom_range(0, 99) < 92, $urandom_range(0, 99) < 6,
                        random_command(), random_command(), 1'($urandom), 1'($urandom),
                        32'(cur_time)), 1'b0);
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off to back the core up, and a quiet stretch.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 24);
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_data.left_duty != want.left_duty)
          report("left_duty", out_data.left_duty, want.left_duty);
        if (out_data.right_duty != want.right_duty)
          report("right_duty", out_data.right_duty, want.right_duty);
        if (out_data.left_level_mv != want.left_level_mv)
          report("left_level_mv", out_data.left_level_mv, want.left_level_mv);
        if (out_data.right_level_mv != want.right_level_mv)
          report("right_level_mv", out_data.right_level_mv, want.right_level_mv);
        if (out_data.left_reverse_out != want.left_reverse_out)
          report("left_reverse_out", out_data.left_reverse_out, want.left_reverse_out);
        if (out_data.right_reverse_out != want.right_reverse_out)
          report("right_reverse_out", out_data.right_reverse_out, want.right_reverse_out);
        if (out_data.drive_enable_out != want.drive_enable_out)
          report("drive_enable_out", out_data.drive_enable_out, want.drive_enable_out);
        if (out_data.brake_out != want.brake_out)
          report("brake_out", out_data.brake_out, want.brake_out);
        if (want.brake_out) stops_seen++;
        checked++;
      end
    end
  end

  initial begin
    #30000000;
    $display("tb_dual_throttle_slew_pwm_core failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int i;
    m_min = 1000; m_max = 4200; m_floor = 800;
    m_rise = 2000; m_fall = 4000; m_fs = 5000;
    m_last_time = 0; m_left = 0; m_right = 0;

    // Stop rows carry a typed expectation; the rest go through the predictor.
    rows.push_back('{make_cmd(0, 0, 16'h4000, 16'h4000, 1, 1, 32'd0), 1'b1});
    rows.push_back('{make_cmd(1, 1, 16'h4000, 16'hC000, 1, 0, 32'd100), 1'b1});
    rows.push_back('{make_cmd(1, 0, 16'h4000, 16'hC000, 0, 0, 32'd100), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h7FFF, 16'h8000, 1, 0, 32'd1100), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h0000, 16'h0000, 0, 1, 32'd1200), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h0001, 16'hFFFF, 0, 0, 32'd1300), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h2000, 16'hE000, 0, 0, 32'd3300), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h7FFF, 16'h7FFF, 1, 1, 32'd3301), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h4000, 16'h0000, 0, 0, 32'hFFFFFFFF), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'hC000, 16'h4000, 0, 0, 32'h00000005), 1'b0});
    rows.push_back('{make_cmd(0, 1, 16'h7FFF, 16'h7FFF, 1, 1, 32'd0), 1'b1});
    rows.push_back('{make_cmd(1, 0, 16'h4000, 16'h4000, 0, 0, 32'd77777), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h4000, 16'h8000, 0, 1, 32'h80000000), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'h7FFF, 16'h8000, 1, 1, 32'h80000400), 1'b0});
    rows.push_back('{make_cmd(1, 1, 16'h7FFF, 16'h8000, 1, 1, 32'h80000500), 1'b1});
    rows.push_back('{make_cmd(1, 0, 16'd4000, -16'sd12000, 0, 0, 32'h80001000), 1'b0});
    rows.push_back('{make_cmd(1, 0, 16'd100, -16'sd100, 1, 0, 32'h80002000), 1'b0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < rows.size(); i++) send_cmd(rows[i].cmd, rows[i].typed);
    in_valid <= 1'b0;
    cur_time = 32'h80002000;

    for (i = 0; i < NUM_PHASES; i++) begin
      case (i)
        0: load_setting(16'd1000, 16'd4200, 16'd800, 20'd2000, 20'd4000, 16'd5000);
        // Minimum above maximum, with the deadband above the maximum too.
        1: load_setting(16'd5000, 16'd2000, 16'd3000, 20'd700, 20'd1500, 16'd4000);
        2: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        // Zero rates freeze the levels; zero full scale forces zero duty.
        3: load_setting(16'd0, 16'd0, 16'd0, 20'd0, 20'd0, 16'd0);
        4: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom),
                        20'($urandom), 16'($urandom));
        default: load_setting(16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 65535)),
                              16'($urandom_range(0, 1500)), 20'($urandom_range(1, 100000)),
                              20'($urandom_range(1, 100000)), 16'($urandom_range(1, 65535)));
      endcase
      random_cmds(RANDOM_PER_PHASE);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d results (%0d stops) from %0d commands over %0d setting phases,",
             checked, stops_seen, items_sent, NUM_PHASES + 1);
    $display("with %0d register writes, random stalls and one long output hold-off.",
             cfg_writes);
    if (errors == 0) begin
      $display("tb_dual_throttle_slew_pwm_core passed");
    end else begin
      $display("tb_dual_throttle_slew_pwm_core failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/dtsp_pkg.sv
sv/dtsp_div.sv
sv/dtsp_lane.sv
sv/dual_throttle_slew_pwm_core.sv
bench/tb_dual_throttle_slew_pwm_core.sv
